// ===== rtl/pise_pkg.sv =====
package pise_pkg;

	localparam int PRICE_W    = 32;
	localparam int SUM_W      = 38;
	localparam int SQ_W       = 64;
	localparam int S2_W       = 70;
	localparam int VAR_W      = 76;
	localparam int RSI_W      = 15;
	localparam int RSI_M_W    = 16;
	localparam int PER_W      = 6;
	localparam int LVL_W      = 15;
	localparam int K_W        = 12;
	localparam int MODE_W     = 2;
	localparam int N2_W       = 12;
	localparam int ROOT_W     = 32;
	localparam int OFF_W      = ROOT_W + K_W - 8;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 15;
	localparam int IN_W       = 64;
	localparam int OUT_W      = 120;
	localparam int CNT_W      = 7;
	localparam int CMP_W      = 16;

	localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RSI_MA  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RSI     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BAND_MA = 2'd3;

	localparam logic [CFG_ADDR_W-1:0] REG_ALGO_MODE   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MA_PERIOD   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RSI_PERIOD  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_BAND_PERIOD = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_OVERSOLD    = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_OVERBOUGHT  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_BAND_K      = 3'd6;

	localparam logic [RSI_M_W-1:0] RSI_FULL = 16'd25600;

	localparam logic [CNT_W-1:0] DRAIN_LAST = 7'd2;
	localparam logic [CNT_W-1:0] DIV_LAST   = 7'd75;
	localparam logic [CNT_W-1:0] SHORT_STEPS = 7'd38;
	localparam logic [CNT_W-1:0] RSI_STEPS  = 7'd16;
	localparam logic [CNT_W-1:0] SQRT_LAST  = 7'd31;

	typedef struct packed {
		logic             accept;
		logic             issue;
		logic [PER_W-1:0] idx;
		logic             var1;
		logic             var2;
		logic             div_step;
		logic             short_step;
		logic             rsi_step;
		logic             sqrt_step;
		logic             mul;
		logic             load_out;
	} cmd_t;

	typedef struct packed {
		logic [PER_W-1:0] walk_last;
	} sts_t;

endpackage

// ===== rtl/pise_dp.sv =====
module pise_dp #(
	parameter int HISTORY_DEPTH = 64,
	parameter int PRICE_WIDTH   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pise_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [pise_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [pise_pkg::IN_W-1:0]         in_data,
	input  pise_pkg::cmd_t                    cmd,
	output pise_pkg::sts_t                    sts,
	output logic [pise_pkg::OUT_W-1:0]        out_data
);
	import pise_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [PRICE_W-1:0] PMASK = (PRICE_WIDTH >= PRICE_W) ? {PRICE_W{1'b1}} :
		PRICE_W'((64'd1 << PRICE_WIDTH) - 64'd1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

	// configuration
	logic [MODE_W-1:0] mode_q;
	logic [PER_W-1:0]  ma_per_q, rsi_per_q, band_per_q;
	logic [LVL_W-1:0]  os_q, ob_q;
	logic [K_W-1:0]    k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NONE;
			ma_per_q   <= 6'd50;
			rsi_per_q  <= 6'd14;
			band_per_q <= 6'd20;
			os_q       <= 15'd7680;
			ob_q       <= 15'd17920;
			k_q        <= 12'd512;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ALGO_MODE:   mode_q     <= cfg_data[MODE_W-1:0];
				REG_MA_PERIOD:   ma_per_q   <= cfg_data[PER_W-1:0];
				REG_RSI_PERIOD:  rsi_per_q  <= cfg_data[PER_W-1:0];
				REG_BAND_PERIOD: band_per_q <= cfg_data[PER_W-1:0];
				REG_OVERSOLD:    os_q       <= cfg_data[LVL_W-1:0];
				REG_OVERBOUGHT:  ob_q       <= cfg_data[LVL_W-1:0];
				REG_BAND_K:      k_q        <= cfg_data[K_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero period acts as one
	logic [PER_W-1:0] mp, rp, bp, maxp;
	assign mp = (ma_per_q == '0) ? PER_W'(1) : ma_per_q;
	assign rp = (rsi_per_q == '0) ? PER_W'(1) : rsi_per_q;
	assign bp = (band_per_q == '0) ? PER_W'(1) : band_per_q;

	always_comb begin
		maxp = mp;
		if (rp > maxp) maxp = rp;
		if (bp > maxp) maxp = bp;
	end
	assign sts.walk_last = maxp - PER_W'(1);

	// history ring
	logic [PRICE_W-1:0] mem [HISTORY_DEPTH];
	logic [PRICE_W-1:0] rd_s1;
	logic [AW-1:0]      slot_q, rd_addr_q;
	logic [CW-1:0]      count_q;
	logic [PRICE_W-1:0] close_in;

	assign close_in = in_data[PRICE_W-1:0] & PMASK;

	always_ff @(posedge clk) begin
		if (cmd.accept) mem[slot_q] <= close_in;
		if (cmd.issue) rd_s1 <= mem[rd_addr_q];
	end

	logic             v_s1, v_s2;
	logic [PER_W-1:0] idx_s1, idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			rd_addr_q <= '0;
			count_q   <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			idx_s1    <= '0;
			idx_s2    <= '0;
		end else begin
			if (cmd.accept) begin
				slot_q    <= (slot_q == LAST_SLOT) ? '0 : slot_q + AW'(1);
				rd_addr_q <= slot_q;
				if (count_q != CW'(HISTORY_DEPTH)) count_q <= count_q + CW'(1);
			end else if (cmd.issue) begin
				rd_addr_q <= (rd_addr_q == '0) ? LAST_SLOT : rd_addr_q - AW'(1);
			end
			v_s1   <= cmd.issue;
			idx_s1 <= cmd.idx;
			v_s2   <= v_s1;
			idx_s2 <= idx_s1;
		end
	end

	// walk datapath: square, then accumulate
	logic [PRICE_W-1:0] x_s2, prev_q, live_q;
	logic [SQ_W-1:0]    sq_s2;
	logic [SUM_W-1:0]   sum_ma_q, s1_q, g_q, l_q;
	logic [S2_W-1:0]    s2_q;

	// variance and divider state
	logic [SQ_W-1:0]        p0_q;
	logic [SUM_W-1:0]       p1_q;
	logic [VAR_W-1:0]       ns2_q, var_dvd_q;
	logic [N2_W-1:0]        var_rem_q;
	logic [SUM_W-1:0]       ma_dvd_q, mn_dvd_q;
	logic [PER_W-1:0]       ma_rem_q, mn_rem_q;
	logic [SUM_W:0]         rsi_d_q, rsi_r_q;
	logic [RSI_M_W-1:0]     rsi_m_q, rsi_qt_q;
	logic [ROOT_W-1:0]      root_q;
	logic [ROOT_W+1:0]      sq_rem_q;
	logic [OFF_W-1:0]       off_q;

	logic [2*PER_W-1:0]     p2;
	logic [VAR_W-1:0]       s1_sqr;
	logic [N2_W-1:0]        n2;
	logic [N2_W:0]          var_rn;
	logic                   var_ge;
	logic [PER_W:0]         ma_rn, mn_rn;
	logic                   ma_ge, mn_ge;
	logic [SUM_W+1:0]       rsi_s, rsi_sub;
	logic                   rsi_ge, rsi_ge2;
	logic [1:0]             rsi_dig;
	logic [ROOT_W+1:0]      sq_rn, sq_trial;
	logic                   sq_ge;
	logic [ROOT_W+K_W-1:0]  prod;

	assign p2     = s1_q[SUM_W-1:PRICE_W] * s1_q[SUM_W-1:PRICE_W];
	assign s1_sqr = VAR_W'(p0_q) + (VAR_W'(p1_q) << (PRICE_W + 1)) + (VAR_W'(p2) << SQ_W);
	assign n2     = bp * bp;

	assign var_rn = {var_rem_q, var_dvd_q[VAR_W-1]};
	assign var_ge = var_rn >= {1'b0, n2};
	assign ma_rn  = {ma_rem_q, ma_dvd_q[SUM_W-1]};
	assign ma_ge  = ma_rn >= {1'b0, mp};
	assign mn_rn  = {mn_rem_q, mn_dvd_q[SUM_W-1]};
	assign mn_ge  = mn_rn >= {1'b0, bp};

	// gain is added unshifted each step, so a quotient digit can reach two
	assign rsi_s   = {rsi_r_q, 1'b0} + (rsi_m_q[RSI_M_W-1] ? (SUM_W+2)'(g_q) : '0);
	assign rsi_ge  = rsi_s >= {1'b0, rsi_d_q};
	assign rsi_ge2 = rsi_s >= {rsi_d_q, 1'b0};
	assign rsi_sub = rsi_ge2 ? {rsi_d_q, 1'b0} : (rsi_ge ? {1'b0, rsi_d_q} : '0);
	assign rsi_dig = {rsi_ge2, rsi_ge & ~rsi_ge2};

	assign sq_rn    = {sq_rem_q[ROOT_W-1:0], var_dvd_q[SQ_W-1:SQ_W-2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge    = sq_rn >= sq_trial;

	assign prod = root_q * k_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) live_q <= in_data[IN_W-1:PRICE_W] & PMASK;
		x_s2  <= rd_s1;
		sq_s2 <= rd_s1 * rd_s1;

		if (cmd.accept) begin
			sum_ma_q <= '0;
			s1_q     <= '0;
			s2_q     <= '0;
			g_q      <= '0;
			l_q      <= '0;
		end else if (v_s2) begin
			if (idx_s2 < mp) sum_ma_q <= sum_ma_q + SUM_W'(x_s2);
			if (idx_s2 < bp) begin
				s1_q <= s1_q + SUM_W'(x_s2);
				s2_q <= s2_q + S2_W'(sq_s2);
			end
			// consecutive differences, newer minus older
			if (idx_s2 != '0 && idx_s2 < rp) begin
				if (prev_q > x_s2) g_q <= g_q + SUM_W'(prev_q - x_s2);
				else l_q <= l_q + SUM_W'(x_s2 - prev_q);
			end
			prev_q <= x_s2;
		end

		if (cmd.var1) begin
			p0_q  <= s1_q[PRICE_W-1:0] * s1_q[PRICE_W-1:0];
			p1_q  <= s1_q[PRICE_W-1:0] * s1_q[SUM_W-1:PRICE_W];
			ns2_q <= s2_q * bp;
		end

		if (cmd.var2) begin
			var_dvd_q <= ns2_q - s1_sqr;
			var_rem_q <= '0;
			ma_dvd_q  <= sum_ma_q;
			ma_rem_q  <= '0;
			mn_dvd_q  <= s1_q;
			mn_rem_q  <= '0;
			rsi_d_q   <= (SUM_W+1)'(g_q) + (SUM_W+1)'(l_q);
			rsi_r_q   <= '0;
			rsi_m_q   <= RSI_FULL;
			rsi_qt_q  <= '0;
			root_q    <= '0;
			sq_rem_q  <= '0;
		end

		if (cmd.div_step) begin
			var_rem_q <= var_ge ? N2_W'(var_rn - {1'b0, n2}) : var_rn[N2_W-1:0];
			var_dvd_q <= {var_dvd_q[VAR_W-2:0], var_ge};
		end
		if (cmd.short_step) begin
			ma_rem_q <= ma_ge ? PER_W'(ma_rn - {1'b0, mp}) : ma_rn[PER_W-1:0];
			ma_dvd_q <= {ma_dvd_q[SUM_W-2:0], ma_ge};
			mn_rem_q <= mn_ge ? PER_W'(mn_rn - {1'b0, bp}) : mn_rn[PER_W-1:0];
			mn_dvd_q <= {mn_dvd_q[SUM_W-2:0], mn_ge};
		end
		if (cmd.rsi_step) begin
			rsi_r_q  <= (SUM_W+1)'(rsi_s - rsi_sub);
			rsi_qt_q <= {rsi_qt_q[RSI_M_W-2:0], 1'b0} + RSI_M_W'(rsi_dig);
			rsi_m_q  <= rsi_m_q << 1;
		end

		// digit-by-digit square root over the low quotient word
		if (cmd.sqrt_step) begin
			var_dvd_q <= var_dvd_q << 2;
			sq_rem_q  <= sq_ge ? sq_rn - sq_trial : sq_rn;
			root_q    <= {root_q[ROOT_W-2:0], sq_ge};
		end

		if (cmd.mul) off_q <= prod[ROOT_W+K_W-1:8];
	end

	// result assembly
	logic               ma_ok, rsi_ok, band_ok, ready;
	logic [PRICE_W-1:0] ma_v, mean, upper, lower;
	logic [RSI_W-1:0]   rsi_v;
	logic [OFF_W:0]     up_w;
	logic               buy, sell;

	assign ma_ok   = CMP_W'(count_q) >= CMP_W'(mp);
	assign rsi_ok  = CMP_W'(count_q) > CMP_W'(rp);
	assign band_ok = CMP_W'(count_q) >= CMP_W'(bp);
	assign ready   = CMP_W'(count_q) >= CMP_W'(maxp) + CMP_W'(2);

	assign ma_v  = ma_ok ? ma_dvd_q[PRICE_W-1:0] : '0;
	assign rsi_v = !rsi_ok ? '0 : (l_q == '0) ? RSI_FULL[RSI_W-1:0] : rsi_qt_q[RSI_W-1:0];
	assign mean  = mn_dvd_q[PRICE_W-1:0];
	assign up_w  = (OFF_W+1)'(mean) + (OFF_W+1)'(off_q);

	always_comb begin
		upper = '0;
		lower = '0;
		if (band_ok) begin
			upper = (up_w > (OFF_W+1)'(PMASK)) ? PMASK : up_w[PRICE_W-1:0];
			lower = (off_q >= OFF_W'(mean)) ? '0 : mean - off_q[PRICE_W-1:0];
		end
	end

	always_comb begin
		buy  = 1'b0;
		sell = 1'b0;
		if (ready) begin
			unique case (mode_q)
				MODE_RSI_MA: begin
					buy  = rsi_v < os_q && live_q > ma_v;
					sell = rsi_v > ob_q && live_q < ma_v;
				end
				MODE_RSI: begin
					buy  = rsi_v < os_q;
					sell = rsi_v > ob_q;
				end
				MODE_BAND_MA: begin
					buy  = live_q < lower && live_q > ma_v;
					sell = live_q > upper && live_q < ma_v;
				end
				default: ;
			endcase
		end
		if (buy) sell = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_data <= {6'd0, ready, sell, buy, lower, upper, rsi_v, ma_v};
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(HISTORY_DEPTH) >= count_q) else $error("close count past depth");
	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_addr_q <= LAST_SLOT && slot_q <= LAST_SLOT) else $error("ring pointer out of range");
	a_tag_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> ##1 v_s2) else $error("walk tag lost");

endmodule

// ===== rtl/pise_ctl.sv =====
module pise_ctl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  pise_pkg::sts_t sts,
	output pise_pkg::cmd_t cmd
);
	import pise_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WALK  = 4'd1;
	localparam logic [3:0] ST_DRAIN = 4'd2;
	localparam logic [3:0] ST_VAR1  = 4'd3;
	localparam logic [3:0] ST_VAR2  = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0]       state_q;
	logic [PER_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.accept     = s_tvalid && s_tready;
		cmd.issue      = state_q == ST_WALK;
		cmd.idx        = idx_q;
		cmd.var1       = state_q == ST_VAR1;
		cmd.var2       = state_q == ST_VAR2;
		cmd.div_step   = state_q == ST_DIV;
		cmd.short_step = state_q == ST_DIV && cnt_q < SHORT_STEPS;
		cmd.rsi_step   = state_q == ST_DIV && cnt_q < RSI_STEPS;
		cmd.sqrt_step  = state_q == ST_SQRT;
		cmd.mul        = state_q == ST_MUL;
		cmd.load_out   = state_q == ST_FIN && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_WALK;
						idx_q   <= '0;
					end
				end
				ST_WALK: begin
					if (idx_q == sts.walk_last) begin
						state_q <= ST_DRAIN;
						cnt_q   <= '0;
					end else begin
						idx_q <= idx_q + PER_W'(1);
					end
				end
				ST_DRAIN: begin
					if (cnt_q == DRAIN_LAST) state_q <= ST_VAR1;
					else cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_VAR1: state_q <= ST_VAR2;
				ST_VAR2: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_SQRT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SQRT: begin
					if (cnt_q == SQRT_LAST) state_q <= ST_MUL;
					else cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_MUL: state_q <= ST_FIN;
				ST_FIN: begin
					if (cmd.load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_WALK && idx_q == '0) else $error("accept did not start walk");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> idx_q <= sts.walk_last) else $error("walk index overran");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid && state_q == ST_IDLE) else $error("result load lost");

endmodule

// ===== rtl/price_indicator_signal_engine_top.sv =====
// Price indicator engine: each input beat appends a close to a history ring and
// yields one result beat with the moving average, Q7.8 RSI, Bollinger bands and
// buy/sell flags for the selected mode. One beat is processed at a time; the result
// is loaded after a one-close-per-cycle walk of the ring through a single read port
// (maxp closes, maxp = largest of the three periods), a pipeline drain, the
// variance states, 76 bit-serial divide steps, 32 square-root steps, a scale step
// and a load step; the load waits while an earlier result is still not taken.
// The finished result sits in an output register, so the next input beat is taken
// while it waits.
module price_indicator_signal_engine_top #(
	parameter int HISTORY_DEPTH = 64,
	parameter int PRICE_WIDTH   = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write port
	input  logic                             cfg_we,
	input  logic [pise_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [pise_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input beats
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pise_pkg::IN_W-1:0]        s_tdata,  // close_price, live_price
	// result beats
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// ma_value, rsi_value, band_upper, band_lower, buy_signal, sell_signal, ready_res
	output logic [pise_pkg::OUT_W-1:0]       m_tdata
);
	import pise_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: walk, drain, variance, divide, root, scale, load
	pise_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ring, accumulators, serial divide/sqrt units, output register
	pise_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.PRICE_WIDTH   (PRICE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_data  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (m_tdata)
	);

endmodule

// ===== tb/pise_checker.sv =====
module pise_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pise_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [pise_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [pise_pkg::IN_W-1:0]       s_tdata,   // close_price, live_price
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [pise_pkg::OUT_W-1:0]      m_tdata,   // ma, rsi, upper, lower, buy, sell, ready
	output int                              pending,
	output int                              fails
);
	timeunit 1ns;
	timeprecision 1ps;
	import pise_pkg::*;

	typedef struct packed {
		logic        ready_res;
		logic        sell;
		logic        buy;
		logic [31:0] lower;
		logic [31:0] upper;
		logic [14:0] rsi;
		logic [31:0] ma;
	} indic_t;

	logic [31:0]       closes [64];
	logic [6:0]        n_closes;
	logic [5:0]        slot;
	logic [MODE_W-1:0] mode;
	logic [5:0]        ma_per, rsi_per, band_per;
	logic [14:0]       lvl_lo, lvl_hi;
	logic [11:0]       k_q48;
	indic_t            expected_q[$];
	int                n_bad;
	int                n_res;

	function automatic logic [31:0] nth_close(int i);
		logic [5:0] idx;
		idx = slot - 6'd1 - 6'(i);
		return closes[idx];
	endfunction

	function automatic logic [6:0] eff(logic [5:0] p);
		return (p == 0) ? 7'd1 : {1'b0, p};
	endfunction

	// advance the history with one close and work out the indicator beat
	function automatic indic_t next_indicators(logic [31:0] close, logic [31:0] live);
		indic_t r;
		logic [6:0] mp, rp, bp, maxp;
		logic [63:0] s, g, l, s1, mean, off, nw, od;
		logic [79:0] s2, v, vr, c;
		logic [32:0] sd;
		logic [15:0] rsi;
		r = '0;
		rsi = 0;
		mp = eff(ma_per);
		rp = eff(rsi_per);
		bp = eff(band_per);
		closes[slot] = close;
		slot = slot + 6'd1;
		if (n_closes < 7'd64)
			n_closes = n_closes + 7'd1;
		if (n_closes >= mp) begin
			s = 0;
			for (int i = 0; i < mp; i++)
				s += nth_close(i);
			r.ma = 32'(s / mp);
		end
		if (n_closes > rp) begin
			g = 0;
			l = 0;
			for (int i = 0; i + 1 < rp; i++) begin
				nw = nth_close(i);
				od = nth_close(i + 1);
				if (nw > od)
					g += nw - od;
				else
					l += od - nw;
			end
			rsi = (l == 0) ? 16'd25600 : 16'((80'(g) * 80'd25600) / 80'(g + l));
			r.rsi = rsi[14:0];
		end
		if (n_closes >= bp) begin
			s1 = 0;
			s2 = 0;
			for (int i = 0; i < bp; i++) begin
				s1 += nth_close(i);
				s2 += 80'(nth_close(i)) * 80'(nth_close(i));
			end
			mean = s1 / bp;
			v = s2 * 80'(bp) - 80'(s1) * 80'(s1);
			vr = v / (80'(bp) * 80'(bp));
			sd = 0;
			for (int b = 32; b >= 0; b--) begin
				c = 80'(sd | (33'd1 << b));
				if (c * c <= vr)
					sd = c[32:0];
			end
			off = (64'(sd) * 64'(k_q48)) >> 8;
			r.upper = (mean + off > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(mean + off);
			r.lower = (off >= mean) ? 32'd0 : 32'(mean - off);
		end
		maxp = mp;
		if (rp > maxp) maxp = rp;
		if (bp > maxp) maxp = bp;
		r.ready_res = (n_closes >= maxp + 7'd2);
		if (r.ready_res) begin
			case (mode)
				MODE_RSI_MA: begin
					r.buy  = rsi < lvl_lo && live > r.ma;
					r.sell = rsi > lvl_hi && live < r.ma;
				end
				MODE_RSI: begin
					r.buy  = rsi < lvl_lo;
					r.sell = rsi > lvl_hi;
				end
				MODE_BAND_MA: begin
					r.buy  = live < r.lower && live > r.ma;
					r.sell = live > r.upper && live < r.ma;
				end
				default: ;
			endcase
		end
		if (r.buy)
			r.sell = 1'b0;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s at result %0d: got %0d want %0d @%0t",
			what, n_res, got, want, $realtime);
		n_bad++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		indic_t got, want;
		if (!arst_n) begin
			n_closes = 0;
			slot     = 0;
			mode     = MODE_NONE;
			ma_per   = 6'd50;
			rsi_per  = 6'd14;
			band_per = 6'd20;
			lvl_lo   = 15'd7680;
			lvl_hi   = 15'd17920;
			k_q48    = 12'd512;
			expected_q.delete();
			n_bad    = 0;
			n_res    = 0;
			pending <= 0;
			fails   <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_ALGO_MODE:   mode     = cfg_data[MODE_W-1:0];
					REG_MA_PERIOD:   ma_per   = cfg_data[5:0];
					REG_RSI_PERIOD:  rsi_per  = cfg_data[5:0];
					REG_BAND_PERIOD: band_per = cfg_data[5:0];
					REG_OVERSOLD:    lvl_lo   = cfg_data[14:0];
					REG_OVERBOUGHT:  lvl_hi   = cfg_data[14:0];
					REG_BAND_K:      k_q48    = cfg_data[11:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_q = {expected_q, next_indicators(s_tdata[31:0], s_tdata[63:32])};
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(indic_t)-1:0];
				if (expected_q.size() == 0) begin
					report("unexpected beat", 0, 0);
				end else begin
					want = expected_q.pop_front();
					if (got.ma !== want.ma)       report("ma_value", got.ma, want.ma);
					if (got.rsi !== want.rsi)     report("rsi_value", got.rsi, want.rsi);
					if (got.upper !== want.upper) report("band_upper", got.upper, want.upper);
					if (got.lower !== want.lower) report("band_lower", got.lower, want.lower);
					if (got.buy !== want.buy)     report("buy_signal", got.buy, want.buy);
					if (got.sell !== want.sell)   report("sell_signal", got.sell, want.sell);
					if (got.ready_res !== want.ready_res)
						report("ready_res", got.ready_res, want.ready_res);
				end
				n_res++;
			end
			pending <= expected_q.size();
			fails   <= n_bad;
		end
	end

endmodule

// ===== tb/tb_price_indicator_signal_engine_top.sv =====
module tb_price_indicator_signal_engine_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pise_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	int                    pending;
	int                    fails;

	// random walk state for the close stream
	logic [31:0] walk;
	int          stall_left = 0;
	bit          calm = 1'b0;   // no sink stalls while set

	always #5 clk = ~clk;

	price_indicator_signal_engine_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	pise_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.pending(pending), .fails(fails)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// sink backpressure; calm stretches toggle slowly
	always @(posedge clk) begin
		if ($urandom_range(0, 2999) == 0)
			calm <= ~calm;
		if (calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else begin
			stall_left <= gap_len();
			m_tready   <= 1'b1;
		end
	end

	task automatic send_beat(logic [31:0] close, logic [31:0] live);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {live, close};
		do @(posedge clk); while (!s_tready);
	endtask

	// wait for the next edge first so the count sees a beat accepted at the current edge
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// whole register set; called only with the engine idle
	task automatic set_regs(logic [1:0] md, logic [5:0] mp, logic [5:0] rp, logic [5:0] bp,
			logic [14:0] lo, logic [14:0] hi, logic [11:0] k);
		wait_drained();
		write_reg(REG_ALGO_MODE, 15'(md));
		write_reg(REG_MA_PERIOD, 15'(mp));
		write_reg(REG_RSI_PERIOD, 15'(rp));
		write_reg(REG_BAND_PERIOD, 15'(bp));
		write_reg(REG_OVERSOLD, lo);
		write_reg(REG_OVERBOUGHT, hi);
		write_reg(REG_BAND_K, 15'(k));
	endtask

	// one random beat: mostly a walk with small moves, sometimes wild values
	task automatic random_beat();
		logic [31:0] c, lv, d;
		int r;
		r = $urandom_range(0, 99);
		d = $urandom_range(0, 3000);
		if (r < 8) begin
			walk = $urandom();
		end else if (r < 11) begin
			walk = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
		end else if ($urandom_range(0, 1) != 0) begin
			walk = (walk > 32'hFFFF_FFFF - d) ? 32'hFFFF_FFFF : walk + d;
		end else begin
			walk = (walk < d) ? 32'd0 : walk - d;
		end
		c = walk;
		r = $urandom_range(0, 99);
		d = $urandom_range(0, 20000);
		if (r < 10)
			lv = $urandom();
		else if (r < 55)
			lv = (c > 32'hFFFF_FFFF - d) ? 32'hFFFF_FFFF : c + d;
		else
			lv = (c < d) ? 32'd0 : c - d;
		send_beat(c, lv);
	endtask

	initial begin
		walk = 32'd100000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero period acting as one, flat window, saturation, extremes
		set_regs(MODE_RSI_MA, 6'd0, 6'd2, 6'd3, 15'd12800, 15'd12800, 12'd4095);
		write_reg(3'd7, 15'h7FFF);   // unused index, must be ignored
		send_beat(32'd0, 32'd0);
		send_beat(32'd0, 32'hFFFF_FFFF);
		send_beat(32'd0, 32'd1);
		send_beat(32'd0, 32'd0);
		send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(32'hFFFF_FFFF, 32'd0);
		send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_beat(32'd0, 32'h8000_0000);
		send_beat(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_beat(32'd0, 32'hFFFF_FFFF);
		send_beat(32'hAAAA_AAAA, 32'h5555_5555);
		send_beat(32'h5555_5555, 32'hAAAA_AAAA);
		set_regs(MODE_RSI, 6'd1, 6'd2, 6'd1, 15'd25600, 15'd0, 12'd0);
		send_beat(32'd10, 32'd5);
		send_beat(32'd20, 32'd5);
		send_beat(32'd15, 32'd5);
		send_beat(32'd15, 32'd5);
		set_regs(MODE_BAND_MA, 6'd2, 6'd3, 6'd4, 15'd32767, 15'd32767, 12'd256);
		send_beat(32'd1000, 32'd999);
		send_beat(32'd1010, 32'd1020);
		send_beat(32'd990, 32'd1);
		send_beat(32'd1005, 32'd2000);
		send_beat(32'd1000, 32'd1003);

		// random phases, several settings including the extremes
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_regs(MODE_RSI_MA, 6'd5, 6'd8, 6'd6, 15'd12800, 15'd12800, 12'd512);
				1: set_regs(MODE_RSI, 6'd1, 6'd2, 6'd1, 15'd25600, 15'd0, 12'd0);
				2: set_regs(MODE_BAND_MA, 6'd20, 6'd14, 6'd20, 15'd7680, 15'd17920, 12'd4095);
				3: set_regs(MODE_RSI_MA, 6'd62, 6'd62, 6'd62, 15'd32767, 15'd32767, 12'd1);
				4: set_regs(MODE_NONE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)), 15'($urandom()), 15'($urandom()),
					12'($urandom()));
				5: set_regs(MODE_BAND_MA, 6'($urandom_range(1, 12)), 6'($urandom_range(2, 12)),
					6'($urandom_range(1, 12)), 15'd7680, 15'd17920,
					12'($urandom_range(0, 1024)));
				6: set_regs(MODE_RSI, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)), 15'($urandom()), 15'($urandom()),
					12'($urandom()));
				default: set_regs(MODE_RSI_MA, 6'($urandom_range(1, 30)),
					6'($urandom_range(2, 30)), 6'($urandom_range(1, 30)),
					15'($urandom_range(0, 25600)), 15'($urandom_range(0, 25600)),
					12'($urandom()));
			endcase
			for (int i = 0; i < 142; i++)
				random_beat();
		end

		wait_drained();
		repeat (300) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#60ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
